>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dqpi_pkg.sv
`default_nettype none

package dqpi_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_D_TARGET   = 3'd0;
  localparam logic [2:0] CFG_Q_TARGET   = 3'd1;
  localparam logic [2:0] CFG_CUR_GAIN   = 3'd2;
  localparam logic [2:0] CFG_PAST_GAIN  = 3'd3;
  localparam logic [2:0] CFG_ANG_OFFSET = 3'd4;

  // Reset values of the configuration registers
  localparam logic signed [15:0] RST_D_TARGET   = 16'sd1024;
  localparam logic signed [15:0] RST_Q_TARGET   = 16'sd1024;
  localparam logic signed [31:0] RST_CUR_GAIN   = 32'sd1127429;
  localparam logic signed [31:0] RST_PAST_GAIN  = -32'sd1020055;
  localparam logic [8:0]         RST_ANG_OFFSET = 9'd0;

  // Regulator output limit, 10.0 in Q8.24
  localparam logic signed [34:0] OUT_TEN    = 35'sd167772160;
  // Half LSB of the Q.41 to Q.24 rescale
  localparam logic signed [50:0] ROUND_HALF = 51'sd65536;
  // Half of 5120, for round-half-away on the drive scale
  localparam logic [27:0]        DRV_BIAS   = 28'd2560;
  // floor(n * RECIP5 / 2^18) == floor(n / 5) for n < 2^18
  localparam logic signed [17:0] RECIP5     = 18'sd52429;
  // floor(a * RECIP30 / 2^16) == floor(a / 30) for a < 360
  localparam logic signed [17:0] RECIP30    = 18'sd2185;
  localparam logic signed [17:0] DEG_TURN   = 18'sd360;
  localparam logic signed [17:0] PCT_SQ     = 18'sd10000;
  localparam logic [9:0]         DEG_360    = 10'd360;
  localparam logic [9:0]         DEG_720    = 10'd720;
  localparam logic [8:0]         DEG_60     = 9'd60;
  localparam logic [15:0]        DRV_MAX    = 16'h7FFF;
  localparam logic [15:0]        ROOT_BIT0  = 16'h4000;
  localparam logic [15:0]        MOD_MIN    = 16'd10;
  localparam logic [15:0]        MOD_MAX    = 16'd90;
  localparam logic [2:0]         ROOT_LAST  = 3'd7;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_CUR,
    OP_MUL_PAST,
    OP_ACC,
    OP_CLAMP,
    OP_DRV_MUL,
    OP_DRV_FIN,
    OP_SQ_D,
    OP_SQ_Q,
    OP_SUM,
    OP_SCALE,
    OP_ROOT_INIT,
    OP_ROOT_STEP,
    OP_ANG_MUL,
    OP_ANG_WRAP,
    OP_ANG_SECT,
    OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PI_CUR,
    S_PI_PAST,
    S_PI_ACC,
    S_PI_CLAMP,
    S_DRV_MUL,
    S_DRV_FIN,
    S_SQ_D,
    S_SQ_Q,
    S_SUM,
    S_SCALE,
    S_ROOT_INIT,
    S_ANG_MUL,
    S_ANG_WRAP,
    S_ANG_SECT,
    S_ROOT_STEP,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t  op;
    logic ch;   // 0: d axis, 1: q axis
  } dqpi_cmd_t;

  typedef struct packed {
    logic out_free;
  } dqpi_stat_t;

endpackage

`default_nettype wire

>>> rtl/dqpi_ctrl.sv
`default_nettype none

module dqpi_ctrl import dqpi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dqpi_stat_t stat,
  output dqpi_cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic       ch_r, ch_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.ch    = ch_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          ch_nxt    = 1'b0;
          state_nxt = S_PI_CUR;
        end
      end
      S_PI_CUR: begin
        cmd.op    = OP_MUL_CUR;
        state_nxt = S_PI_PAST;
      end
      S_PI_PAST: begin
        cmd.op    = OP_MUL_PAST;
        state_nxt = S_PI_ACC;
      end
      S_PI_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = S_PI_CLAMP;
      end
      S_PI_CLAMP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = S_DRV_MUL;
      end
      S_DRV_MUL: begin
        cmd.op    = OP_DRV_MUL;
        state_nxt = S_DRV_FIN;
      end
      S_DRV_FIN: begin
        cmd.op = OP_DRV_FIN;
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = S_PI_CUR;
        end else begin
          state_nxt = S_SQ_D;
        end
      end
      S_SQ_D: begin
        cmd.op    = OP_SQ_D;
        state_nxt = S_SQ_Q;
      end
      S_SQ_Q: begin
        cmd.op    = OP_SQ_Q;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        cmd.op    = OP_ROOT_INIT;
        cnt_nxt   = '0;
        state_nxt = S_ANG_MUL;
      end
      S_ANG_MUL: begin
        cmd.op    = OP_ANG_MUL;
        state_nxt = S_ANG_WRAP;
      end
      S_ANG_WRAP: begin
        cmd.op    = OP_ANG_WRAP;
        state_nxt = S_ANG_SECT;
      end
      S_ANG_SECT: begin
        cmd.op    = OP_ANG_SECT;
        state_nxt = S_ROOT_STEP;
      end
      S_ROOT_STEP: begin
        cmd.op  = OP_ROOT_STEP;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == ROOT_LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold here until the output register can take the result
        if (stat.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dqpi_datapath.sv
`default_nettype none

module dqpi_datapath import dqpi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dqpi_cmd_t          cmd,
  output dqpi_stat_t         stat,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [15:0] in_d_current,
  input  logic signed [15:0] in_q_current,
  input  logic [15:0]        in_grid_angle,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [3:0]         out_sector,
  output logic [6:0]         out_mod_index,
  output logic [5:0]         out_sector_angle,
  output logic signed [15:0] out_d_drive,
  output logic [14:0]        out_q_drive
);

  // configuration
  logic signed [15:0] tgt_d_r, tgt_q_r;
  logic signed [31:0] gain_cur_r, gain_past_r;
  logic [8:0]         ang_off_r;

  // regulator history
  logic signed [16:0] perr_r [2];
  logic signed [16:0] perr_nxt [2];
  logic signed [31:0] pout_r [2];
  logic signed [31:0] pout_nxt [2];

  // working registers
  logic signed [16:0] err_r [2];
  logic signed [16:0] err_nxt [2];
  logic signed [15:0] drv_r [2];
  logic signed [15:0] drv_nxt [2];
  logic [15:0]        ang_r, ang_nxt;
  logic signed [50:0] prod_r, prod_nxt;
  logic signed [50:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic [15:0]        x_r, x_nxt;
  logic [15:0]        root_r, root_nxt;
  logic [15:0]        bit_r, bit_nxt;
  logic [8:0]         ang_a_r, ang_a_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         sector_r, sector_nxt;
  logic [6:0]         mod_r, mod_nxt;
  logic [5:0]         sang_r, sang_nxt;
  logic signed [15:0] dd_r, dd_nxt;
  logic [14:0]        qd_r, qd_nxt;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;

  // combinational helpers
  logic signed [31:0] pv;
  logic signed [34:0] y_sum, y_lo;
  logic signed [31:0] y_cl;
  logic [31:0]        pabs;
  logic [27:0]        drv_bias;
  logic [17:0]        drv_n;
  logic [15:0]        drv_q;
  logic [15:0]        root_t;
  logic [9:0]         ang_sum;
  logic [3:0]         sidx;
  logic [8:0]         sang_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_d_r     <= RST_D_TARGET;
      tgt_q_r     <= RST_Q_TARGET;
      gain_cur_r  <= RST_CUR_GAIN;
      gain_past_r <= RST_PAST_GAIN;
      ang_off_r   <= RST_ANG_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_D_TARGET:   tgt_d_r     <= cfg_wdata[15:0];
        CFG_Q_TARGET:   tgt_q_r     <= cfg_wdata[15:0];
        CFG_CUR_GAIN:   gain_cur_r  <= cfg_wdata;
        CFG_PAST_GAIN:  gain_past_r <= cfg_wdata;
        CFG_ANG_OFFSET: ang_off_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perr_r[0]   <= '0;
      perr_r[1]   <= '0;
      pout_r[0]   <= '0;
      pout_r[1]   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      perr_r      <= perr_nxt;
      pout_r      <= pout_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r    <= err_nxt;
    drv_r    <= drv_nxt;
    ang_r    <= ang_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    neg_r    <= neg_nxt;
    x_r      <= x_nxt;
    root_r   <= root_nxt;
    bit_r    <= bit_nxt;
    ang_a_r  <= ang_a_nxt;
    sector_r <= sector_nxt;
    mod_r    <= mod_nxt;
    sang_r   <= sang_nxt;
    dd_r     <= dd_nxt;
    qd_r     <= qd_nxt;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_CUR: begin
        mul_a = {gain_cur_r[31], gain_cur_r};
        mul_b = {err_r[cmd.ch][16], err_r[cmd.ch]};
      end
      OP_MUL_PAST: begin
        mul_a = {gain_past_r[31], gain_past_r};
        mul_b = {perr_r[cmd.ch][16], perr_r[cmd.ch]};
      end
      OP_DRV_MUL: begin
        mul_a = {15'd0, drv_n};
        mul_b = RECIP5;
      end
      OP_SQ_D: begin
        mul_a = {{17{drv_r[0][15]}}, drv_r[0]};
        mul_b = {{2{drv_r[0][15]}}, drv_r[0]};
      end
      OP_SQ_Q: begin
        mul_a = {{17{drv_r[1][15]}}, drv_r[1]};
        mul_b = {{2{drv_r[1][15]}}, drv_r[1]};
      end
      OP_SCALE: begin
        mul_a = acc_r[32:0];
        mul_b = PCT_SQ;
      end
      OP_ANG_MUL: begin
        mul_a = {17'd0, ang_r};
        mul_b = DEG_TURN;
      end
      OP_ANG_SECT: begin
        mul_a = {24'd0, ang_a_r};
        mul_b = RECIP30;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounded Q.24 sum plus the held output, then the axis limits
  assign pv    = pout_r[cmd.ch];
  assign y_sum = {acc_r[50], acc_r[50:17]} + {{3{pv[31]}}, pv};
  assign y_lo  = cmd.ch ? 35'sd0 : -OUT_TEN;
  always_comb begin
    if (y_sum > OUT_TEN) begin
      y_cl = OUT_TEN[31:0];
    end else if (y_sum < y_lo) begin
      y_cl = y_lo[31:0];
    end else begin
      y_cl = y_sum[31:0];
    end
  end

  // drive = round(|out| / 5120): /1024 by shift, /5 by reciprocal
  assign pabs     = pv[31] ? (~pv + 32'd1) : pv;
  assign drv_bias = pabs[27:0] + DRV_BIAS;
  assign drv_n    = drv_bias[27:10];
  assign drv_q    = prod_r[33:18];

  assign root_t  = root_r + bit_r;
  assign ang_sum = {1'b0, prod_r[24:16]} + {1'b0, ang_off_r};
  assign sidx    = prod_r[19:16];
  assign sang_full = ang_a_r - ({6'd0, sidx[3:1]} * DEG_60);

  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    perr_nxt      = perr_r;
    pout_nxt      = pout_r;
    err_nxt       = err_r;
    drv_nxt       = drv_r;
    ang_nxt       = ang_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    ang_a_nxt     = ang_a_r;
    sector_nxt    = sector_r;
    mod_nxt       = mod_r;
    sang_nxt      = sang_r;
    dd_nxt        = dd_r;
    qd_nxt        = qd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (cmd.op)
      OP_LOAD: begin
        err_nxt[0] = {tgt_d_r[15], tgt_d_r} - {in_d_current[15], in_d_current};
        err_nxt[1] = {tgt_q_r[15], tgt_q_r} - {in_q_current[15], in_q_current};
        ang_nxt    = in_grid_angle;
      end
      OP_MUL_CUR: begin
        prod_nxt = mul_p;
      end
      OP_MUL_PAST, OP_SQ_Q: begin
        acc_nxt  = prod_r;
        prod_nxt = mul_p;
      end
      OP_ACC: begin
        acc_nxt = acc_r + prod_r + ROUND_HALF;
      end
      OP_CLAMP: begin
        pout_nxt[cmd.ch] = y_cl;
        perr_nxt[cmd.ch] = err_r[cmd.ch];
      end
      OP_DRV_MUL: begin
        prod_nxt = mul_p;
        neg_nxt  = pv[31];
      end
      OP_DRV_FIN: begin
        if (neg_r) begin
          drv_nxt[cmd.ch] = ~drv_q + 16'd1;
        end else if (drv_q > DRV_MAX) begin
          drv_nxt[cmd.ch] = DRV_MAX;
        end else begin
          drv_nxt[cmd.ch] = drv_q;
        end
      end
      OP_SQ_D, OP_SCALE, OP_ANG_MUL, OP_ANG_SECT: begin
        prod_nxt = mul_p;
      end
      OP_SUM: begin
        acc_nxt = acc_r + prod_r;
      end
      OP_ROOT_INIT: begin
        x_nxt    = {1'b0, prod_r[44:30]};
        root_nxt = '0;
        bit_nxt  = ROOT_BIT0;
      end
      OP_ROOT_STEP: begin
        if (x_r >= root_t) begin
          x_nxt    = x_r - root_t;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
      OP_ANG_WRAP: begin
        if (ang_sum >= DEG_720) begin
          ang_a_nxt = 9'(ang_sum - DEG_720);
        end else if (ang_sum >= DEG_360) begin
          ang_a_nxt = 9'(ang_sum - DEG_360);
        end else begin
          ang_a_nxt = ang_sum[8:0];
        end
      end
      OP_FINISH: begin
        sector_nxt = sidx + 4'd1;
        sang_nxt   = sang_full[5:0];
        if (root_r > MOD_MAX) begin
          mod_nxt = MOD_MAX[6:0];
        end else if (root_r < MOD_MIN) begin
          mod_nxt = MOD_MIN[6:0];
        end else begin
          mod_nxt = root_r[6:0];
        end
        dd_nxt        = drv_r[0];
        qd_nxt        = drv_r[1][14:0];
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_sector       = sector_r;
  assign out_mod_index    = mod_r;
  assign out_sector_angle = sang_r;
  assign out_d_drive      = dd_r;
  assign out_q_drive      = qd_r;

endmodule

`default_nettype wire

>>> rtl/dq_current_pi_modulation_sector.sv
// dq-frame PI current regulator with modulation index and sector split.
// Input channel (in_valid/in_ready): one transaction per control sample,
// measured d and q currents in Q5.11 and a 16-bit grid angle.
// Output channel (out_valid/out_ready): one transaction per input, with
// sector 1..12, modulation index 10..90, angle within the 60 degree
// span, the d drive in Q1.15 and the q drive in unsigned Q0.15.
// Config port: cfg_we writes cfg_wdata into register cfg_index
// (0 d target, 1 q target, 2 present gain, 3 past gain, 4 angle
// offset); other indexes are dropped. Write only while the block is idle.
// Timing: in_ready rises at the same edge at which the result is loaded
// into the output register; while a transaction is in progress no new
// one is taken. The sequence is set by one shared 33x18 multiplier stepped
// through both regulators, the drive scaling and the squares, plus the
// steps of the digit-by-digit square root.
// Reset: config returns to defaults, regulator history clears to zero.
// Stall: a result held by out_ready low does not block the next input;
// the following result waits in its last step until the register frees.
`default_nettype none

`include "assert_macros.svh"

module dq_current_pi_modulation_sector import dqpi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_d_current,
  input  logic signed [15:0] in_q_current,
  input  logic [15:0]        in_grid_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_sector,
  output logic [6:0]         out_mod_index,
  output logic [5:0]         out_sector_angle,
  output logic signed [15:0] out_d_drive,
  output logic [14:0]        out_q_drive,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  dqpi_cmd_t  cmd;
  dqpi_stat_t stat;
  logic       out_fields_ok;

  // sequencer: walks d regulator, q regulator, magnitude, angle, result
  dqpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic, config, regulator history and the result register
  dqpi_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_d_current     (in_d_current),
    .in_q_current     (in_q_current),
    .in_grid_angle    (in_grid_angle),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_sector       (out_sector),
    .out_mod_index    (out_mod_index),
    .out_sector_angle (out_sector_angle),
    .out_d_drive      (out_d_drive),
    .out_q_drive      (out_q_drive)
  );

  assign out_fields_ok = (out_sector >= 4'd1) && (out_sector <= 4'd12) &&
                         (out_mod_index >= 7'd10) && (out_mod_index <= 7'd90) &&
                         (out_sector_angle <= 6'd59);

  // a held result always carries clamped, wrapped fields
  `ASSERT_IMPLY(a_out_range, out_valid, out_fields_ok, "result field out of range")

  // once a transaction is taken the sequencer is busy
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

  // a new result only appears at the end of a busy sequence
  `ASSERT_IMPLY(a_result_from_busy, $rose(out_valid), !$past(in_ready), "result without work")

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking bench for the dq-frame PI current regulator.
// Stimulus: directed corners first, then random phases, each phase
// with its own register setting. The scoreboard predicts every result
// from the accepted input transactions and its own copy of the regulator
// history, and checks each output transaction field by field.
module tb;
  import dqpi_pkg::*;

  // One input transaction, as driven on the in_ ports
  typedef struct packed {
    logic signed [15:0] d_current;
    logic signed [15:0] q_current;
    logic [15:0]        grid_angle;
  } sample_t;

  // One output transaction, as seen on the out_ ports
  typedef struct packed {
    logic [3:0]         sector;
    logic [6:0]         mod_index;
    logic [5:0]         sector_angle;
    logic signed [15:0] d_drive;
    logic [14:0]        q_drive;
  } result_t;

  localparam longint REG_LIMIT   = 167772160;  // +/-10.0 in Q8.24
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     LONG_HOLD   = 400;        // receiver hold-off, cycles
  localparam int     REG_SLOTS   = 8;          // whole 3-bit index space

  // Scoreboard: register copy, regulator history, pending predictions.
  class dq_regulator_scoreboard;
    longint  d_target, q_target, gain_now, gain_past, ang_offset;
    longint  prev_err[2];
    longint  prev_out[2];
    result_t expected_outputs[$];
    int      error_count;

    function void clear();
      d_target   = 1024;
      q_target   = 1024;
      gain_now   = 1127429;
      gain_past  = -1020055;
      ang_offset = 0;
      prev_err   = '{0, 0};
      prev_out   = '{0, 0};
      expected_outputs.delete();
      error_count = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_D_TARGET:   d_target   = longint'($signed(data[15:0]));
        CFG_Q_TARGET:   q_target   = longint'($signed(data[15:0]));
        CFG_CUR_GAIN:   gain_now   = longint'($signed(data));
        CFG_PAST_GAIN:  gain_past  = longint'($signed(data));
        CFG_ANG_OFFSET: ang_offset = longint'(data[8:0]);
        default: ;  // unmapped index: write dropped
      endcase
    endfunction

    // Bilinear PI step: Q.41 product sum, round half up to Q.24, add, clamp
    function longint pi_update(int ax, longint err, longint lo, longint hi);
      longint acc, y;
      acc = gain_now * err + gain_past * prev_err[ax];
      y = ((acc + 65536) >>> 17) + prev_out[ax];
      if (y > hi) y = hi;
      if (y < lo) y = lo;
      prev_err[ax] = err;
      prev_out[ax] = y;
      return y;
    endfunction

    // Q8.24 times 0.1 to Q1.15, round half away from zero, saturate
    function longint drive_of(longint y);
      longint mag, d;
      mag = (y < 0) ? -y : y;
      d = (mag + 2560) / 5120;
      if (y < 0) begin
        d = -d;
        if (d < -32768) d = -32768;
      end else if (d > 32767) begin
        d = 32767;
      end
      return d;
    endfunction

    function longint floor_sqrt(longint x);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= x) r++;
      return r;
    endfunction

    function result_t predict_outputs(sample_t s);
      longint  vd, vq, m, deg, a;
      result_t r;
      vd = drive_of(pi_update(0, d_target - longint'($signed(s.d_current)),
                              -REG_LIMIT, REG_LIMIT));
      vq = drive_of(pi_update(1, q_target - longint'($signed(s.q_current)),
                              0, REG_LIMIT));
      m = floor_sqrt(((vd * vd + vq * vq) * 10000) >>> 30);
      if (m > 90) m = 90;
      if (m < 10) m = 10;
      deg = (longint'(s.grid_angle) * 360) >>> 16;
      a = (deg + ang_offset) % 360;
      r.sector       = 4'(a / 30 + 1);
      r.mod_index    = 7'(m);
      r.sector_angle = 6'(a % 60);
      r.d_drive      = 16'(vd);
      r.q_drive      = 15'(vq);
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_outputs.push_back(predict_outputs(s));
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        error_count++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_outputs.size() == 0) begin
        error_count++;
        $display("%0t: output transaction with nothing pending: expected none, actual %p",
                 $time, got);
        return;
      end
      want = expected_outputs.pop_front();
      check_field("sector",       want.sector,       got.sector);
      check_field("mod_index",    want.mod_index,    got.mod_index);
      check_field("sector_angle", want.sector_angle, got.sector_angle);
      check_field("d_drive",      want.d_drive,      got.d_drive);
      check_field("q_drive",      want.q_drive,      got.q_drive);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_d_current;
  logic signed [15:0] in_q_current;
  logic [15:0]        in_grid_angle;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_sector;
  logic [6:0]         out_mod_index;
  logic [5:0]         out_sector_angle;
  logic signed [15:0] out_d_drive;
  logic [14:0]        out_q_drive;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;

  dq_regulator_scoreboard board;
  bit                     long_hold_req;  // stimulus asks receiver for a long hold-off
  int                     cycle_count = 0;

  dq_current_pi_modulation_sector i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_d_current     (in_d_current),
    .in_q_current     (in_q_current),
    .in_grid_angle    (in_grid_angle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sector       (out_sector),
    .out_mod_index    (out_mod_index),
    .out_sector_angle (out_sector_angle),
    .out_d_drive      (out_d_drive),
    .out_q_drive      (out_q_drive),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Output monitor: every accepted output transaction goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result({out_sector, out_mod_index, out_sector_angle,
                          out_d_drive, out_q_drive});
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver: stretches of always-ready, random stalls, sparse ready and
  // toggling, plus one long hold-off on request so the block backs up.
  initial begin : receiver
    int hold_left;
    int run_left;
    int style;
    hold_left = 0;
    run_left  = 0;
    style     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 40);
          style    = $urandom_range(0, 3);
        end
        run_left--;
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  function automatic sample_t mk_sample(int d, int q, int a);
    sample_t s;
    s.d_current  = 16'(d);
    s.q_current  = 16'(q);
    s.grid_angle = 16'(a);
    return s;
  endfunction

  // Current within about one amp of the target, clipped to the Q5.11 range
  function automatic logic [15:0] near_target(longint t);
    longint v;
    v = t + longint'($urandom_range(0, 4096)) - 2048;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // Mostly near-target currents so the loops settle; the rest full-scale noise
  function automatic sample_t random_sample();
    sample_t s;
    if ($urandom_range(0, 9) < 6) begin
      s.d_current = near_target(board.d_target);
      s.q_current = near_target(board.q_target);
    end else begin
      s.d_current = 16'($urandom);
      s.q_current = 16'($urandom);
    end
    s.grid_angle = 16'($urandom);
    return s;
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return 16'($urandom_range(0, 16384) - 8192);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, so the caller either drives the next
  // transaction or drops valid there.
  task automatic send_sample(sample_t s);
    in_valid      <= 1'b1;
    in_d_current  <= s.d_current;
    in_q_current  <= s.q_current;
    in_grid_angle <= s.grid_angle;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(s);
    @(negedge clk);
  endtask

  task automatic hold_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Sender pause: nothing offered until every pending result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_outputs.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Full register set; unused upper data bits carry junk
  task automatic load_config(logic [15:0] dt, logic [15:0] qt,
                             logic [31:0] g0, logic [31:0] g1, logic [8:0] off);
    write_reg(CFG_D_TARGET,   {16'($urandom), dt});
    write_reg(CFG_Q_TARGET,   {16'($urandom), qt});
    write_reg(CFG_CUR_GAIN,   g0);
    write_reg(CFG_PAST_GAIN,  g1);
    write_reg(CFG_ANG_OFFSET, {23'($urandom), off});
  endtask

  task automatic random_config();
    logic [15:0] dt, qt;
    logic [31:0] g0, g1;
    dt = pick_target();
    qt = pick_target();
    case ($urandom_range(0, 3))
      0, 1: begin
        // plausible PI pair: a0 > 0, a1 slightly smaller and negative
        g0 = $urandom_range(1 << 16, 1 << 26);
        g1 = -(g0 - $urandom_range(0, g0 / 8));
      end
      2: begin
        g0 = $urandom;
        g1 = $urandom;
      end
      default: begin
        g0 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        g1 = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
    endcase
    load_config(dt, qt, g0, g1, 9'($urandom_range(0, 511)));
    if ($urandom_range(0, 1))
      write_reg(3'($urandom_range(CFG_ANG_OFFSET + 1, REG_SLOTS - 1)), $urandom);
  endtask

  // Random bursts with random gaps; halfway through, optionally ask the
  // receiver for a long hold-off and keep offering back to back.
  task automatic random_phase(int n_items, bit with_hold);
    int sent;
    int burst_left;
    int gap;
    sent       = 0;
    burst_left = 0;
    while (sent < n_items) begin
      if (with_hold && sent == n_items / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        long_hold_req = 1'b1;
        @(negedge clk);
        burst_left = 10;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap > 0) hold_input(gap);
      end
      send_sample(random_sample());
      sent++;
      burst_left--;
    end
  endtask

  initial begin : stimulus
    board = new();
    board.clear();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_d_current  = '0;
    in_q_current  = '0;
    in_grid_angle = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    long_hold_req = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset config: field extremes, bit patterns, sector edges at 30 degrees.
    // Small reset gains keep the modulation index at its lower clamp.
    send_sample(mk_sample(0, 0, 0));
    send_sample(mk_sample(32767, 32767, 65535));
    send_sample(mk_sample(-32768, -32768, 32768));
    send_sample(mk_sample(1024, 1024, 5461));
    send_sample(mk_sample(1024, 1024, 5462));
    send_sample(mk_sample('h5555, 'hAAAA, 'h5555));
    send_sample(mk_sample('hAAAA, 'h5555, 'hAAAA));
    hold_input(3);
    send_sample(mk_sample(-1, 1, 182));
    wait_drained();

    // Writes to unmapped indexes must leave the setting alone
    for (int i = CFG_ANG_OFFSET + 1; i < REG_SLOTS; i++)
      write_reg(3'(i), $urandom);
    send_sample(mk_sample(0, 0, 10923));
    send_sample(mk_sample(512, -512, 60075));
    wait_drained();

    // Largest positive gains, full-scale targets, offset beyond one turn:
    // both regulators pin at +10, drives saturate, index hits its top clamp
    load_config(16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 9'd511);
    send_sample(mk_sample(-32768, -32768, 65535));
    send_sample(mk_sample(0, 0, 0));
    send_sample(mk_sample(32767, 32767, 32768));
    wait_drained();

    // Most negative gains and targets, offset at the top of the turn
    load_config(16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000, 9'd359);
    send_sample(mk_sample(32767, 32767, 65535));
    send_sample(mk_sample(-32768, -32768, 1));
    send_sample(mk_sample(0, 0, 21845));
    wait_drained();

    // Opposite-sign extremes, offset above 359
    load_config(16'h8000, 16'h7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 9'd400);
    send_sample(mk_sample(32767, -32768, 65535));
    send_sample(mk_sample(-32768, 32767, 49152));
    wait_drained();

    // Random phases; one of them carries the long receiver hold-off
    for (int p = 0; p < 8; p++) begin
      random_config();
      random_phase(48, p == 3);
      wait_drained();
    end

    repeat (40) @(negedge clk);
    if (board.error_count == 0 && board.expected_outputs.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
